// ----- rtl/core/mmtb_pkg.sv -----
// Package for the multi-mode timer bank: slot count, field widths, codes,
// and the packed slot entry kept in the slot memory. No dependencies.
package mmtb_pkg;

  localparam int SLOTS   = 8;
  localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int MASK_W  = 8;

  localparam int OP_W   = 2;
  localparam int IDX_W  = 3;
  localparam int MODE_W = 2;
  localparam int IVAL_W = 24;
  localparam int CNT_W  = 17;
  localparam int PROG_W = 25;
  localparam int TIME_W = 32;
  localparam int FRAC_W = 8;
  localparam int DAY_W  = 17;
  localparam int HOUR_W = 12;

  localparam logic [OP_W-1:0] OP_TICK    = 2'd0;
  localparam logic [OP_W-1:0] OP_CREATE  = 2'd1;
  localparam logic [OP_W-1:0] OP_DESTROY = 2'd2;

  localparam logic [MODE_W-1:0] MODE_FRAME = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SEC   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_DAY   = 2'd2;
  localparam logic [MODE_W-1:0] MODE_HOUR  = 2'd3;

  localparam logic [CNT_W-1:0] FOREVER = CNT_W'(-255);

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [IVAL_W-1:0] interval;
    logic [CNT_W-1:0]  repeats;
    logic [PROG_W-1:0] progress;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

  typedef struct packed {
    logic [TIME_W-1:0] now;
    logic [DAY_W-1:0]  day_s;
    logic [HOUR_W-1:0] hour_s;
  } tick_info_t;

endpackage

// ----- rtl/core/mmtb_if.sv -----
// Channel interfaces for the multi-mode timer bank: input and result
// transactions with valid/ready. Depends on mmtb_pkg.
interface mmtb_in_if;
  logic                          valid;
  logic                          ready;
  logic [mmtb_pkg::OP_W-1:0]     op;
  logic [mmtb_pkg::IDX_W-1:0]    slot;
  logic [mmtb_pkg::MODE_W-1:0]   timer_mode;
  logic [mmtb_pkg::IVAL_W-1:0]   interval_value;
  logic signed [mmtb_pkg::CNT_W-1:0] loop_count;
  logic [mmtb_pkg::TIME_W-1:0]   now_time;
  logic [mmtb_pkg::DAY_W-1:0]    day_seconds;
  logic [mmtb_pkg::HOUR_W-1:0]   hour_seconds;

  modport source (output valid, op, slot, timer_mode, interval_value, loop_count,
                  now_time, day_seconds, hour_seconds, input ready);
  modport sink   (input valid, op, slot, timer_mode, interval_value, loop_count,
                  now_time, day_seconds, hour_seconds, output ready);
endinterface

interface mmtb_out_if;
  logic                          valid;
  logic                          ready;
  logic [mmtb_pkg::MASK_W-1:0]   fired_mask;
  logic [mmtb_pkg::MASK_W-1:0]   active_mask;

  modport source (output valid, fired_mask, active_mask, input ready);
  modport sink   (input valid, fired_mask, active_mask, output ready);
endinterface

// ----- rtl/core/mmtb_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module mmtb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/core/mmtb_slot_upd.sv -----
// Per-slot tick update: frame, seconds, daily and hourly timer rules.
// Depends on mmtb_pkg.
module mmtb_slot_upd (
  input  mmtb_pkg::slot_entry_t cur,
  input  mmtb_pkg::tick_info_t  tick,
  output mmtb_pkg::slot_entry_t nxt,
  output logic                  fire,
  output logic                  expire
);
  import mmtb_pkg::*;

  logic [PROG_W-1:0] prog_inc;
  logic [PROG_W-1:0] deadline;
  logic [IVAL_W-1:0] sec;

  always_comb begin
    nxt      = cur;
    fire     = 1'b0;
    prog_inc = cur.progress + PROG_W'(1);
    deadline = PROG_W'(tick.now[TIME_W-1:FRAC_W]) + PROG_W'(cur.interval);
    sec      = (cur.mode == MODE_DAY) ? IVAL_W'(tick.day_s) : IVAL_W'(tick.hour_s);
    case (cur.mode)
      MODE_FRAME: begin
        if (prog_inc >= PROG_W'(cur.interval)) begin
          nxt.progress = '0;
          fire         = 1'b1;
        end else begin
          nxt.progress = prog_inc;
        end
      end
      MODE_SEC: begin
        if ({1'b0, tick.now} > {cur.progress, {FRAC_W{1'b0}}}) begin
          nxt.progress = deadline;
          fire         = 1'b1;
        end
      end
      default: begin
        if (sec >= cur.interval) begin
          if (cur.progress == '0) begin
            fire         = 1'b1;
            nxt.progress = PROG_W'(1);
          end
        end else begin
          nxt.progress = '0;
        end
      end
    endcase
    if (fire && cur.repeats != FOREVER) begin
      nxt.repeats = cur.repeats - CNT_W'(1);
    end
    expire = (nxt.repeats != FOREVER) && (nxt.repeats[CNT_W-1] || nxt.repeats == '0);
  end
endmodule

// ----- rtl/core/multi_mode_timer_bank.sv -----
// Multi-mode timer bank top level: slot memory, tick sweep sequencer, result register.
// Depends on mmtb_pkg, mmtb_if, mmtb_ram and mmtb_slot_upd.
//
//   channel   dir   transaction
//   in_ch     in    op, slot, timer_mode, interval_value, loop_count, times
//   out_ch    out   fired_mask, active_mask (one per input transaction)
//
// A tick sweep reads one slot per cycle through the single read port of the slot
// memory and writes each slot back in the cycle after its read. Create, destroy and
// unused codes skip the sweep.
// Reset clears the active bits and control; slot memory content needs no reset.
// A result waiting on out_ch holds the next result back, not the next input.
module multi_mode_timer_bank (
  input  logic       clk,
  input  logic       rst_n,
  mmtb_in_if.sink    in_ch,
  mmtb_out_if.source out_ch
);
  import mmtb_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_SWEEP, ST_DONE} state_t;

  state_t              state_r;
  logic [SLOTS-1:0]    active_r;
  logic [SLOT_AW:0]    cnt_r;
  logic                pend_r;
  logic [SLOT_AW-1:0]  pend_idx_r;
  logic [OP_W-1:0]     op_r;
  tick_info_t          tick_r;
  logic [MASK_W-1:0]   fired_acc_r;
  logic                out_valid_r;
  logic [MASK_W-1:0]   out_fired_r;
  logic [MASK_W-1:0]   out_active_r;

  logic                in_acc;
  logic                slot_ok;
  logic [SLOT_AW-1:0]  in_idx;
  logic                rd_issue;
  logic                pend_live;
  logic                ram_we;
  logic [SLOT_AW-1:0]  ram_waddr;
  slot_entry_t         ram_wdata;
  slot_entry_t         ram_rdata;
  slot_entry_t         new_entry;
  slot_entry_t         upd_entry;
  logic                upd_fire;
  logic                upd_expire;
  logic [MASK_W-1:0]   live_mask;
  logic [MASK_W-1:0]   fire_bits;

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign in_acc             = in_ch.valid && in_ch.ready;
  assign slot_ok            = int'(in_ch.slot) < SLOTS;
  assign in_idx             = SLOT_AW'(in_ch.slot);
  assign rd_issue           = (state_r == ST_SWEEP) && (cnt_r < (SLOT_AW + 1)'(SLOTS));
  assign pend_live          = pend_r && active_r[pend_idx_r];

  assign out_ch.valid       = out_valid_r;
  assign out_ch.fired_mask  = out_fired_r;
  assign out_ch.active_mask = out_active_r;

  always_comb begin
    new_entry.mode     = in_ch.timer_mode;
    new_entry.interval = in_ch.interval_value;
    if (in_ch.timer_mode[1] || in_ch.loop_count[CNT_W-1]) begin
      new_entry.repeats = FOREVER;
    end else begin
      new_entry.repeats = in_ch.loop_count;
    end
    new_entry.progress = (in_ch.timer_mode == MODE_SEC) ? PROG_W'(in_ch.interval_value)
                                                        : '0;
  end

  always_comb begin
    ram_we    = pend_live || (in_acc && in_ch.op == OP_CREATE && slot_ok);
    ram_waddr = pend_r ? pend_idx_r : in_idx;
    ram_wdata = pend_r ? upd_entry : new_entry;
  end

  always_comb begin
    for (int i = 0; i < MASK_W; i++) begin
      live_mask[i] = (i < SLOTS) && active_r[SLOT_AW'(i)];
      fire_bits[i] = pend_live && upd_fire && (int'(pend_idx_r) == i);
    end
  end

  mmtb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt_r[SLOT_AW-1:0]),
    .rdata (ram_rdata)
  );

  mmtb_slot_upd u_slot_upd (
    .cur    (ram_rdata),
    .tick   (tick_r),
    .nxt    (upd_entry),
    .fire   (upd_fire),
    .expire (upd_expire)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      active_r    <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r != ST_DONE && out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      pend_r     <= rd_issue;
      pend_idx_r <= cnt_r[SLOT_AW-1:0];
      if (pend_live) begin
        fired_acc_r <= fired_acc_r | fire_bits;
        if (upd_expire) begin
          active_r[pend_idx_r] <= 1'b0;
        end
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            op_r        <= in_ch.op;
            tick_r      <= '{now: in_ch.now_time, day_s: in_ch.day_seconds,
                             hour_s: in_ch.hour_seconds};
            fired_acc_r <= '0;
            cnt_r       <= '0;
            case (in_ch.op)
              OP_TICK: begin
                state_r <= ST_SWEEP;
              end
              OP_CREATE: begin
                if (slot_ok) begin
                  active_r[in_idx] <= 1'b1;
                end
                state_r <= ST_DONE;
              end
              OP_DESTROY: begin
                if (slot_ok) begin
                  active_r[in_idx] <= 1'b0;
                end
                state_r <= ST_DONE;
              end
              default: begin
                state_r <= ST_DONE;
              end
            endcase
          end
        end
        ST_SWEEP: begin
          if (rd_issue) begin
            cnt_r <= cnt_r + (SLOT_AW + 1)'(1);
          end else if (!pend_r) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r  <= 1'b1;
            out_fired_r  <= fired_acc_r;
            out_active_r <= live_mask;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTH
  a_ram_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == ST_SWEEP && pend_r) || (in_acc && in_ch.op == OP_CREATE))
    else $error("slot memory written outside sweep or create");

  a_pend_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> state_r == ST_SWEEP)
    else $error("pending slot read outside sweep");

  a_no_fire_off_tick: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && op_r != OP_TICK) |-> fired_acc_r == '0)
    else $error("fired bits on a non-tick transaction");

  a_sweep_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(state_r == ST_SWEEP) |-> $past(in_acc) && $past(in_ch.op) == OP_TICK)
    else $error("sweep started without a tick");
`endif

endmodule

// ----- verif/multi_mode_timer_bank_checker.sv -----
// Checker for the multi-mode timer bank: watches both channels, keeps its own
// copy of the slot table, predicts the masks of each input transaction and
// compares them in order. Depends on mmtb_pkg and mmtb_if.
module multi_mode_timer_bank_checker (
  input  logic clk,
  input  logic rst_n,
  mmtb_in_if   in_ch,
  mmtb_out_if  out_ch,
  output int   fail_count,
  output int   outstanding,
  output int   results_checked,
  output int   slot_firings
);
  import mmtb_pkg::*;

  localparam int ENDLESS    = -255;
  localparam int PRINT_CAP  = 100;

  typedef struct packed {
    logic [MASK_W-1:0] fired;
    logic [MASK_W-1:0] active;
  } masks_t;

  logic              slot_live [SLOTS];
  logic [MODE_W-1:0] slot_kind [SLOTS];
  logic [IVAL_W-1:0] slot_ival [SLOTS];
  int                slot_left [SLOTS];
  logic [PROG_W-1:0] slot_prog [SLOTS];

  masks_t masks_due[$];
  masks_t want;

  initial begin
    fail_count      = 0;
    outstanding     = 0;
    results_checked = 0;
    slot_firings    = 0;
  end

  task automatic report_mismatch(input string msg);
    if (fail_count < PRINT_CAP) begin
      $display("MISMATCH at %0t: %s", $time, msg);
    end
    fail_count++;
  endtask

  function automatic masks_t apply_transaction(
    input logic [OP_W-1:0]          op,
    input logic [IDX_W-1:0]         idx,
    input logic [MODE_W-1:0]        md,
    input logic [IVAL_W-1:0]        ival,
    input logic signed [CNT_W-1:0]  lc,
    input logic [TIME_W-1:0]        now,
    input logic [DAY_W-1:0]         day_s,
    input logic [HOUR_W-1:0]        hour_s
  );
    masks_t           res;
    logic             hit;
    logic [DAY_W-1:0] sec;
    res = '0;
    case (op)
      OP_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_live[i]) begin
            hit = 1'b0;
            case (slot_kind[i])
              MODE_FRAME: begin
                slot_prog[i] = slot_prog[i] + 1'b1;
                if (slot_prog[i] >= PROG_W'(slot_ival[i])) begin
                  slot_prog[i] = '0;
                  hit = 1'b1;
                end
              end
              MODE_SEC: begin
                // compare the full fixed-point time against the integer deadline
                if ({1'b0, now} > {slot_prog[i], {FRAC_W{1'b0}}}) begin
                  slot_prog[i] = PROG_W'(now[TIME_W-1:FRAC_W]) + PROG_W'(slot_ival[i]);
                  hit = 1'b1;
                end
              end
              default: begin
                sec = (slot_kind[i] == MODE_DAY) ? day_s : DAY_W'(hour_s);
                if (IVAL_W'(sec) >= slot_ival[i]) begin
                  if (slot_prog[i] == '0) begin
                    hit = 1'b1;
                    slot_prog[i] = PROG_W'(1);
                  end
                end else begin
                  slot_prog[i] = '0;
                end
              end
            endcase
            if (hit) begin
              if (i < MASK_W) res.fired[i] = 1'b1;
              if (slot_left[i] != ENDLESS) slot_left[i]--;
            end
            if (slot_left[i] != ENDLESS && slot_left[i] <= 0) slot_live[i] = 1'b0;
          end
        end
      end
      OP_CREATE: begin
        if (int'(idx) < SLOTS) begin
          slot_live[idx] = 1'b1;
          slot_kind[idx] = md;
          slot_ival[idx] = ival;
          slot_left[idx] = (md == MODE_DAY || md == MODE_HOUR || lc[CNT_W-1]) ?
                           ENDLESS : int'(lc);
          slot_prog[idx] = (md == MODE_SEC) ? PROG_W'(ival) : '0;
        end
      end
      OP_DESTROY: begin
        if (int'(idx) < SLOTS) slot_live[idx] = 1'b0;
      end
      default: ;
    endcase
    for (int i = 0; i < SLOTS && i < MASK_W; i++) begin
      res.active[i] = slot_live[i];
    end
    return res;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_live[i] = 1'b0;
        slot_kind[i] = '0;
        slot_ival[i] = '0;
        slot_left[i] = 0;
        slot_prog[i] = '0;
      end
      masks_due.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        want = apply_transaction(in_ch.op, in_ch.slot, in_ch.timer_mode, in_ch.interval_value,
                                 in_ch.loop_count, in_ch.now_time, in_ch.day_seconds,
                                 in_ch.hour_seconds);
        slot_firings += $countones(want.fired);
        masks_due.push_back(want);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (masks_due.size() == 0) begin
          report_mismatch($sformatf("result with nothing pending: fired=%02h active=%02h",
                                    out_ch.fired_mask, out_ch.active_mask));
        end else begin
          want = masks_due.pop_front();
          results_checked++;
          if (out_ch.fired_mask !== want.fired) begin
            report_mismatch($sformatf("fired_mask %02h, predicted %02h",
                                      out_ch.fired_mask, want.fired));
          end
          if (out_ch.active_mask !== want.active) begin
            report_mismatch($sformatf("active_mask %02h, predicted %02h",
                                      out_ch.active_mask, want.active));
          end
        end
      end
    end
    outstanding = masks_due.size();
  end

endmodule

// ----- verif/multi_mode_timer_bank_tb.sv -----
// Testbench top for the multi-mode timer bank: clock, reset, directed and
// random create/destroy/tick/unused transactions, result back-pressure and verdict.
// Depends on mmtb_pkg, mmtb_if, multi_mode_timer_bank and its checker.
module multi_mode_timer_bank_tb;
  import mmtb_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_ITEMS   = 1000;
  localparam int IDLE_PCT       = 7;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 2 * (SLOTS + 4);
  localparam int DAY_LEN        = 86400;
  localparam int HOUR_LEN       = 3600;

  typedef struct {
    logic [OP_W-1:0]         op;
    logic [IDX_W-1:0]        slot;
    logic [MODE_W-1:0]       timer_mode;
    logic [IVAL_W-1:0]       interval_value;
    logic signed [CNT_W-1:0] loop_count;
    logic [TIME_W-1:0]       now_time;
    logic [DAY_W-1:0]        day_seconds;
    logic [HOUR_W-1:0]       hour_seconds;
  } item_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  bit   steady = 1'b0;

  int ticks_sent, creates_sent, destroys_sent, unused_sent;
  int fail_count, outstanding, results_checked, slot_firings;
  int idle_cycles;
  logic [TIME_W-1:0] sim_fx;

  mmtb_in_if  in_ch ();
  mmtb_out_if out_ch ();

  multi_mode_timer_bank dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  multi_mode_timer_bank_checker bank_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .fail_count      (fail_count),
    .outstanding     (outstanding),
    .results_checked (results_checked),
    .slot_firings    (slot_firings)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    out_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  function automatic item_t random_fields();
    item_t it;
    it.op             = OP_W'($urandom_range(0, 3));
    it.slot           = IDX_W'($urandom_range(0, SLOTS - 1));
    it.timer_mode     = MODE_W'($urandom_range(0, 3));
    it.interval_value = IVAL_W'($urandom);
    it.loop_count     = CNT_W'(int'($urandom_range(0, 65536)) - 1);
    it.now_time       = $urandom;
    it.day_seconds    = DAY_W'($urandom_range(0, DAY_LEN - 1));
    it.hour_seconds   = HOUR_W'($urandom_range(0, HOUR_LEN - 1));
    return it;
  endfunction

  function automatic item_t tick_item(input logic [TIME_W-1:0] now, input int day_s,
                                      input int hour_s);
    item_t it;
    it              = random_fields();
    it.op           = OP_TICK;
    it.now_time     = now;
    it.day_seconds  = DAY_W'(day_s);
    it.hour_seconds = HOUR_W'(hour_s);
    return it;
  endfunction

  function automatic item_t create_item(input int idx, input logic [MODE_W-1:0] md,
                                        input int ival, input int lc);
    item_t it;
    it                = random_fields();
    it.op             = OP_CREATE;
    it.slot           = IDX_W'(idx);
    it.timer_mode     = md;
    it.interval_value = IVAL_W'(ival);
    it.loop_count     = CNT_W'(lc);
    return it;
  endfunction

  function automatic item_t destroy_item(input int idx);
    item_t it;
    it      = random_fields();
    it.op   = OP_DESTROY;
    it.slot = IDX_W'(idx);
    return it;
  endfunction

  task automatic send_item(input item_t it);
    if (!steady) begin
      while ($urandom_range(0, 99) < IDLE_PCT) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid          <= 1'b1;
    in_ch.op             <= it.op;
    in_ch.slot           <= it.slot;
    in_ch.timer_mode     <= it.timer_mode;
    in_ch.interval_value <= it.interval_value;
    in_ch.loop_count     <= it.loop_count;
    in_ch.now_time       <= it.now_time;
    in_ch.day_seconds    <= it.day_seconds;
    in_ch.hour_seconds   <= it.hour_seconds;
    case (it.op)
      OP_TICK:    ticks_sent++;
      OP_CREATE:  creates_sent++;
      OP_DESTROY: destroys_sent++;
      default:    unused_sent++;
    endcase
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    item_t it;
    int    pick;
    int    secs;
    in_ch.valid          = 1'b0;
    in_ch.op             = OP_TICK;
    in_ch.slot           = '0;
    in_ch.timer_mode     = MODE_FRAME;
    in_ch.interval_value = '0;
    in_ch.loop_count     = '0;
    in_ch.now_time       = '0;
    in_ch.day_seconds    = '0;
    in_ch.hour_seconds   = '0;
    out_ch.ready         = 1'b0;
    ticks_sent    = 0;
    creates_sent  = 0;
    destroys_sent = 0;
    unused_sent   = 0;
    sim_fx        = $urandom;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // empty table, free-slot destroy, unused code
    send_item(tick_item(32'h0, 0, 0));
    send_item(destroy_item(3));
    it = random_fields();
    it.op = OP_UNUSED;
    send_item(it);
    // fill every slot across modes and extremes
    send_item(create_item(0, MODE_FRAME, 0, 0));
    send_item(create_item(1, MODE_FRAME, 2, -1));
    send_item(create_item(2, MODE_SEC, 0, 1));
    send_item(create_item(3, MODE_DAY, 0, 5));
    send_item(create_item(4, MODE_HOUR, HOUR_LEN - 1, 0));
    send_item(create_item(5, MODE_FRAME, 24'hFF_FFFF, 65535));
    send_item(create_item(6, MODE_SEC, 24'hFF_FFFF, -1));
    send_item(create_item(7, MODE_FRAME, 1, 2));
    send_item(tick_item(32'h0000_0100, 0, HOUR_LEN - 1));
    send_item(tick_item(32'hFFFF_FFFF, DAY_LEN - 1, 0));
    send_item(tick_item(32'h0, 0, HOUR_LEN - 1));
    // reuse an expired slot, destroy a live slot
    send_item(create_item(7, MODE_HOUR, 10, 3));
    send_item(destroy_item(1));
    // zero count: ticked at the exact deadline, no fire, not updated, then dropped
    send_item(create_item(1, MODE_SEC, 3, 0));
    send_item(tick_item(32'h0000_0300, 5, 5));
    send_item(create_item(2, MODE_SEC, 2, 2));
    send_item(tick_item(32'h0000_0201, 20, 20));
    send_item(destroy_item(5));
    send_item(destroy_item(6));

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 300 && n < 550);
      pick = $urandom_range(0, 99);
      secs = int'(sim_fx >> FRAC_W);
      if (pick < 45) begin
        // advance a coherent clock, occasionally jumping across hour boundaries
        if ($urandom_range(0, 99) < 6) begin
          sim_fx += TIME_W'($urandom_range(100, 4000)) << FRAC_W;
        end else begin
          sim_fx += TIME_W'($urandom_range(0, 3 * 256));
        end
        secs = int'(sim_fx >> FRAC_W);
        it = tick_item(sim_fx, secs % DAY_LEN, secs % HOUR_LEN);
      end else if (pick < 50) begin
        it = tick_item($urandom, $urandom_range(0, DAY_LEN - 1),
                       $urandom_range(0, HOUR_LEN - 1));
      end else if (pick < 80) begin
        it = random_fields();
        it.op = OP_CREATE;
        case (it.timer_mode)
          MODE_FRAME, MODE_SEC: begin
            if ($urandom_range(0, 9) < 7) it.interval_value = IVAL_W'($urandom_range(0, 6));
          end
          MODE_DAY: begin
            if ($urandom_range(0, 9) < 8) begin
              it.interval_value = IVAL_W'((secs + $urandom_range(0, 8)) % DAY_LEN);
            end
          end
          default: begin
            if ($urandom_range(0, 9) < 8) begin
              it.interval_value = IVAL_W'((secs + $urandom_range(0, 8)) % HOUR_LEN);
            end
          end
        endcase
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
          it.loop_count = CNT_W'(-1);
        end else if (pick < 8) begin
          it.loop_count = CNT_W'($urandom_range(0, 4));
        end
      end else if (pick < 95) begin
        it = destroy_item($urandom_range(0, SLOTS - 1));
      end else begin
        it = random_fields();
        it.op = OP_UNUSED;
      end
      send_item(it);
    end
    steady = 1'b0;
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d ticks, %0d creates, %0d destroys, %0d unused codes",
             ticks_sent, creates_sent, destroys_sent, unused_sent);
    $display("Checked %0d results covering %0d slot firings, %0d mismatches",
             results_checked, slot_firings, fail_count);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
